// ===== rtl/max_pool_2d_edge_clamped_unit_assert.svh =====
// Assertion macros for the edge-clamped max pooling unit.
`ifndef MAX_POOL_2D_EDGE_CLAMPED_UNIT_ASSERT_SVH
`define MAX_POOL_2D_EDGE_CLAMPED_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MP2D_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define MP2D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MP2D_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define MP2D_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/mp2d_pkg.sv =====
// Types and constants shared by the edge-clamped max pooling unit.
`default_nettype none
package mp2d_pkg;
  localparam int VALUE_BITS = 16;
  localparam int COORD_BITS = 6;
  localparam int CHAN_BITS = 4;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 7;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAP_WIDTH = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAP_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATCH_SIZE = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_SIZE = 3'd4;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  typedef struct packed {
    logic                         req_type;
    logic [COORD_BITS-1:0]        row;
    logic [COORD_BITS-1:0]        col;
    logic [CHAN_BITS-1:0]         chan;
    logic signed [VALUE_BITS-1:0] sample;
  } req_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] pooled;
    logic                         status;
  } rsp_item_t;
endpackage
`default_nettype wire

// ===== rtl/mp2d_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module mp2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/max_pool_2d_edge_clamped_unit.sv =====
// Edge-clamped strided 2-D max pooling over one feature map held in memory.
// Items arrive on req (req_valid / req_stall) and each one returns exactly one
// item on rsp (rsp_valid / rsp_stall); an item is taken when valid is high and
// stall is low. A write stores one element, channel innermost; a query returns
// the maximum over the patch whose origin is the output coordinate times the
// step, with rows and columns past the map clamped to the last one.
// A write, or a query outside the output range, goes from the idle state
// straight to the finish state, which loads the response register.
// A valid query passes through the read state, one element read per cycle
// through the single read port of the map memory, then the drain state for
// the registered read and the finish state that loads the result. In both
// cases the next item is taken once the unit is back in the idle state.
// The unit works on one item at a time and takes the next item while the
// previous response still waits in the output register. Registers are written
// on the cfg channel, which is always ready outside reset; they should only
// change while the unit is idle.
// Reset restores the register defaults and empties the output register; the
// map memory is not cleared and holds no meaning until written. While the
// receiver stalls, a finished item waits in the unit and no new item is taken
// until the output register is free.
`default_nettype none
`include "max_pool_2d_edge_clamped_unit_assert.svh"
module max_pool_2d_edge_clamped_unit
  import mp2d_pkg::*;
#(
  parameter int MAX_WIDTH = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_CHANNELS = 16,
  parameter int MAX_PATCH = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  output logic                           req_stall,
  input  wire req_item_t                 req,
  output logic                           rsp_valid,
  input  wire logic                      rsp_stall,
  output rsp_item_t                      rsp,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);
  localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state;

  logic [6:0] map_width;
  logic [6:0] map_height;
  logic [4:0] channel_count;
  logic [3:0] patch_size;
  logic [3:0] step_size;

  logic [6:0] w_eff;
  logic [6:0] h_eff;
  logic [4:0] nc_eff;
  logic [3:0] p_eff;
  logic [3:0] s_eff;

  always_comb begin
    if (map_width == 7'd0) begin
      w_eff = 7'd1;
    end else if (32'(map_width) > MAX_WIDTH) begin
      w_eff = 7'(MAX_WIDTH);
    end else begin
      w_eff = map_width;
    end
    if (map_height == 7'd0) begin
      h_eff = 7'd1;
    end else if (32'(map_height) > MAX_HEIGHT) begin
      h_eff = 7'(MAX_HEIGHT);
    end else begin
      h_eff = map_height;
    end
    if (channel_count == 5'd0) begin
      nc_eff = 5'd1;
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      nc_eff = 5'(MAX_CHANNELS);
    end else begin
      nc_eff = channel_count;
    end
    if (patch_size == 4'd0) begin
      p_eff = 4'd1;
    end else if (32'(patch_size) > MAX_PATCH) begin
      p_eff = 4'(MAX_PATCH);
    end else begin
      p_eff = patch_size;
    end
    s_eff = (step_size == 4'd0) ? 4'd1 : step_size;
  end

  logic       req_accept;
  logic       write_bad;
  logic       query_bad;
  logic [9:0] oy_in;
  logic [9:0] ox_in;
  logic [6:0] h_room;
  logic [6:0] w_room;

  assign req_stall = rst || (state != ST_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign cfg_ready = !rst;

  assign oy_in = 10'(req.row) * 10'(s_eff);
  assign ox_in = 10'(req.col) * 10'(s_eff);
  assign h_room = h_eff - 7'(p_eff);
  assign w_room = w_eff - 7'(p_eff);

  assign write_bad = (7'(req.row) >= h_eff) || (7'(req.col) >= w_eff) ||
                     (5'(req.chan) >= nc_eff);
  assign query_bad = (7'(p_eff) > h_eff) || (7'(p_eff) > w_eff) ||
                     (oy_in > 10'(h_room)) || (ox_in > 10'(w_room)) ||
                     (5'(req.chan) >= nc_eff);

  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_waddr;
  logic [ADDR_BITS-1:0]  ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  assign ram_we = req_accept && (req.req_type == REQ_WRITE) && !write_bad;
  assign ram_waddr = ADDR_BITS'((32'(req.row) * MAX_WIDTH + 32'(req.col)) * MAX_CHANNELS
                                + 32'(req.chan));

  logic [9:0]           oy;
  logic [9:0]           ox;
  logic [CHAN_BITS-1:0] chan;
  logic [3:0]           py;
  logic [3:0]           px;
  logic                 is_query;
  logic                 is_err;
  logic                 rd_valid;
  logic signed [VALUE_BITS-1:0] best;

  logic [10:0] y_sum;
  logic [10:0] x_sum;
  logic [6:0]  h_lim;
  logic [6:0]  w_lim;
  logic [6:0]  y_pos;
  logic [6:0]  x_pos;

  assign h_lim = h_eff - 7'd1;
  assign w_lim = w_eff - 7'd1;
  assign y_sum = 11'(oy) + 11'(py);
  assign x_sum = 11'(ox) + 11'(px);
  assign y_pos = (y_sum > 11'(h_lim)) ? h_lim : y_sum[6:0];
  assign x_pos = (x_sum > 11'(w_lim)) ? w_lim : x_sum[6:0];
  assign ram_raddr = ADDR_BITS'((32'(y_pos) * MAX_WIDTH + 32'(x_pos)) * MAX_CHANNELS
                                + 32'(chan));

  mp2d_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(DEPTH),
    .ADDR_BITS(ADDR_BITS)
  ) u_map_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(req.sample),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width <= 7'd64;
      map_height <= 7'd64;
      channel_count <= 5'd16;
      patch_size <= 4'd2;
      step_size <= 4'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAP_WIDTH: map_width <= cfg_data[6:0];
        CFG_MAP_HEIGHT: map_height <= cfg_data[6:0];
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[4:0];
        CFG_PATCH_SIZE: patch_size <= cfg_data[3:0];
        CFG_STEP_SIZE: step_size <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rsp_valid <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_READ);
      if (rd_valid && ($signed(ram_rdata) > best)) begin
        best <= $signed(ram_rdata);
      end
      if (rsp_valid && !rsp_stall && (state != ST_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_accept) begin
            oy <= oy_in;
            ox <= ox_in;
            chan <= req.chan;
            py <= 4'd0;
            px <= 4'd0;
            best <= {1'b1, {(VALUE_BITS-1){1'b0}}};
            is_query <= (req.req_type == REQ_QUERY);
            if (req.req_type == REQ_QUERY) begin
              is_err <= query_bad;
              state <= query_bad ? ST_FINISH : ST_READ;
            end else begin
              is_err <= write_bad;
              state <= ST_FINISH;
            end
          end
        end
        ST_READ: begin
          if (px == p_eff - 4'd1) begin
            px <= 4'd0;
            if (py == p_eff - 4'd1) begin
              state <= ST_DRAIN;
            end else begin
              py <= py + 4'd1;
            end
          end else begin
            px <= px + 4'd1;
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp.status <= is_err ? STATUS_ERROR : STATUS_DONE;
            rsp.pooled <= (is_query && !is_err) ? best : '0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `MP2D_ASSERT_SAME(a_rsp_from_finish, clk, rst, $rose(rsp_valid), $past(state) == ST_FINISH, "response loaded outside the finish state")
  `MP2D_ASSERT_SAME(a_read_in_query, clk, rst, rd_valid, (state == ST_READ) || (state == ST_DRAIN), "read data returned outside a query")
  `MP2D_ASSERT_NEXT(a_write_zero, clk, rst, (state == ST_FINISH) && !is_query && (!rsp_valid || !rsp_stall), rsp_valid && (rsp.pooled == '0), "write item returned a nonzero value")
endmodule
`default_nettype wire
